/* rtl/core/qmuh_pkg.sv */
`default_nettype none
package qmuh_pkg;

  // input op codes; 6 and 7 are unused and ignored
  typedef enum logic [2:0] {
    OP_LOAD_SYN  = 3'd0,
    OP_APPEND0   = 3'd1,
    OP_APPEND1   = 3'd2,
    OP_SCORE     = 3'd3,
    OP_READ_HIST = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // result kinds
  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_HIST  = 1'b1;

  // ring_size register
  localparam logic [14:0] RING_RESET = 15'd12323;
  localparam logic [14:0] RING_MIN   = 15'd2;

  // saturating bin limit
  localparam logic [31:0] BIN_MAX = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic ld_syn;    // write one syndrome bit
    logic app0;      // append to block 0 list
    logic app1;      // append to block 1 list
    logic clr;       // clear both histograms
    logic issue;     // issue one index read into the score pipe
    logic hist_upc;  // histogram address from upc count (else from bin)
    logic hist_wr;   // write incremented bin back
    logic out_load;  // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic score_ok;    // scored position below 2r
    logic list_empty;  // selected index list holds nothing
    logic issue_last;  // current issue is the last index
    logic pipe_busy;   // score pipe still holds reads
    logic out_free;    // output register can take a result
  } st_t;

endpackage
`default_nettype wire

/* rtl/core/qmuh_in_if.sv */
`default_nettype none
interface qmuh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [14:0] position;
  logic [13:0] index_value;
  logic        bit_value;

  modport source (output valid, op, position, index_value, bit_value, input ready);
  modport sink   (input valid, op, position, index_value, bit_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/qmuh_out_if.sv */
`default_nettype none
interface qmuh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  upc_count;
  logic [31:0] error_bin_count;
  logic [31:0] correct_bin_count;
  logic        result_kind;

  modport source (output valid, upc_count, error_bin_count, correct_bin_count, result_kind,
                  input ready);
  modport sink   (input valid, upc_count, error_bin_count, correct_bin_count, result_kind,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/qc_mdpc_upc_counter_histogram_unit.sv */
`default_nettype none
// Score: the index walk issues one index-memory read per cycle into a pipe of add,
// two remainder stages and a syndrome read, followed by a read-modify-write of the
// histogram bin. Histogram readout reads both bins, then loads the output register;
// loads, appends and clear take effect on acceptance.
// Reset clears list counts and histogram bin valid bits and sets ring_size to 12323;
// syndrome and index memories keep their contents undefined until written.
module qc_mdpc_upc_counter_histogram_unit
  import qmuh_pkg::*;
#(
  parameter int MAX_RING   = 16384,
  parameter int MAX_WEIGHT = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qmuh_in_if.sink          in_if,
  qmuh_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // ring_size register at byte address 0
  logic [14:0] ring_q;
  logic        ring_sel;

  assign ring_sel = (paddr[2] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = ring_sel ? {17'd0, ring_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RING_RESET;
    end else if (psel && penable && pwrite && pready && ring_sel) begin
      ring_q <= pwdata[14:0];
    end
  end

  cmd_t cmd;
  st_t  st;

  qmuh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_op_i   (in_if.op),
    .in_ready_o(in_if.ready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  qmuh_datapath #(
    .MAX_RING  (MAX_RING),
    .MAX_WEIGHT(MAX_WEIGHT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .ring_i             (ring_q),
    .position_i         (in_if.position),
    .index_value_i      (in_if.index_value),
    .bit_value_i        (in_if.bit_value),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .upc_count_o        (out_if.upc_count),
    .error_bin_count_o  (out_if.error_bin_count),
    .correct_bin_count_o(out_if.correct_bin_count),
    .result_kind_o      (out_if.result_kind)
  );

endmodule
`default_nettype wire

/* rtl/core/qmuh_ram.sv */
`default_nettype none
module qmuh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/qmuh_ctrl.sv */
`default_nettype none
module qmuh_ctrl
  import qmuh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] in_op_i,
  output logic            in_ready_o,
  input  wire st_t        st_i,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_START,
    ST_SC_ISSUE,
    ST_SC_DRAIN,
    ST_SC_RD,
    ST_SC_WR,
    ST_HR_RD,
    ST_HR_OUT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.ld_syn   = accept && (in_op_i == OP_LOAD_SYN);
    cmd_o.app0     = accept && (in_op_i == OP_APPEND0);
    cmd_o.app1     = accept && (in_op_i == OP_APPEND1);
    cmd_o.clr      = accept && (in_op_i == OP_CLEAR);
    cmd_o.issue    = (state_q == ST_SC_ISSUE);
    cmd_o.hist_upc = (state_q == ST_SC_RD) || (state_q == ST_SC_WR);
    cmd_o.hist_wr  = (state_q == ST_SC_WR) && st_i.out_free;
    cmd_o.out_load = ((state_q == ST_SC_WR) || (state_q == ST_HR_OUT)) && st_i.out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_SCORE)) begin
          state_d = ST_SC_START;
        end else if (accept && (in_op_i == OP_READ_HIST)) begin
          state_d = ST_HR_RD;
        end
      end
      ST_SC_START: begin
        if (!st_i.score_ok) begin
          state_d = ST_IDLE;
        end else if (st_i.list_empty) begin
          state_d = ST_SC_RD;
        end else begin
          state_d = ST_SC_ISSUE;
        end
      end
      ST_SC_ISSUE: begin
        if (st_i.issue_last) state_d = ST_SC_DRAIN;
      end
      ST_SC_DRAIN: begin
        if (!st_i.pipe_busy) state_d = ST_SC_RD;
      end
      ST_SC_RD:  state_d = ST_SC_WR;
      ST_SC_WR: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      ST_HR_RD:  state_d = ST_HR_OUT;
      ST_HR_OUT: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/qmuh_datapath.sv */
`default_nettype none
module qmuh_datapath
  import qmuh_pkg::*;
#(
  parameter int MAX_RING   = 16384,
  parameter int MAX_WEIGHT = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output st_t              st_o,
  input  wire logic [14:0] ring_i,
  input  wire logic [14:0] position_i,
  input  wire logic [13:0] index_value_i,
  input  wire logic        bit_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       upc_count_o,
  output logic [31:0]      error_bin_count_o,
  output logic [31:0]      correct_bin_count_o,
  output logic             result_kind_o
);

  localparam int SAW = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;
  localparam int IAW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
  localparam int CW  = $clog2(MAX_WEIGHT + 1);
  localparam int HD  = MAX_WEIGHT + 1;
  localparam int HAW = $clog2(HD);

  // effective ring size, clamped to 2..MAX_RING
  logic [16:0] ring_ext, r_ext;
  logic [14:0] r;
  logic [15:0] r16, r2;

  assign ring_ext = {2'b00, ring_i};
  always_comb begin
    if (ring_i < RING_MIN) begin
      r_ext = 17'(RING_MIN);
    end else if (ring_ext > 17'(MAX_RING)) begin
      r_ext = 17'(MAX_RING);
    end else begin
      r_ext = ring_ext;
    end
  end
  assign r   = r_ext[14:0];
  assign r16 = {1'b0, r};
  assign r2  = {r, 1'b0};

  // index list counts
  logic [CW-1:0] cnt0_q, cnt1_q;
  logic          app0_we, app1_we;

  assign app0_we = cmd_i.app0 && (cnt0_q < CW'(MAX_WEIGHT));
  assign app1_we = cmd_i.app1 && (cnt1_q < CW'(MAX_WEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q <= '0;
      cnt1_q <= '0;
    end else begin
      if (app0_we) cnt0_q <= cnt0_q + CW'(1);
      if (app1_we) cnt1_q <= cnt1_q + CW'(1);
    end
  end

  // latch transaction fields
  logic          in_lo, in_ok;
  logic [14:0]   p_q;
  logic          blk_q, bit_q, score_ok_q, bin_ok_q;
  logic [CW-1:0] n_q;
  logic [HAW-1:0] bin_q;

  assign in_lo = {1'b0, position_i} < r16;
  assign in_ok = {1'b0, position_i} < r2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_q        <= in_lo ? position_i : 15'(position_i - r);
      blk_q      <= !in_lo;
      bit_q      <= bit_value_i;
      score_ok_q <= in_ok;
      n_q        <= in_lo ? cnt0_q : cnt1_q;
      bin_ok_q   <= {2'b00, position_i} <= 17'(MAX_WEIGHT);
      bin_q      <= position_i[HAW-1:0];
    end
  end

  // index and syndrome memories
  logic [IAW-1:0] k_addr;
  logic [13:0]    idx0_rd, idx1_rd, idx_rd;
  logic [SAW-1:0] syn_raddr;
  logic           syn_rd, syn_we;

  assign syn_we = cmd_i.ld_syn && ({2'b00, position_i} < 17'(MAX_RING));

  qmuh_ram #(.WIDTH(1), .DEPTH(MAX_RING)) u_syn_ram (
    .clk_i  (clk_i),
    .we_i   (syn_we),
    .waddr_i(SAW'(position_i)),
    .wdata_i(bit_value_i),
    .raddr_i(syn_raddr),
    .rdata_o(syn_rd)
  );

  qmuh_ram #(.WIDTH(14), .DEPTH(MAX_WEIGHT)) u_idx0_ram (
    .clk_i  (clk_i),
    .we_i   (app0_we),
    .waddr_i(cnt0_q[IAW-1:0]),
    .wdata_i(index_value_i),
    .raddr_i(k_addr),
    .rdata_o(idx0_rd)
  );

  qmuh_ram #(.WIDTH(14), .DEPTH(MAX_WEIGHT)) u_idx1_ram (
    .clk_i  (clk_i),
    .we_i   (app1_we),
    .waddr_i(cnt1_q[IAW-1:0]),
    .wdata_i(index_value_i),
    .raddr_i(k_addr),
    .rdata_o(idx1_rd)
  );

  assign idx_rd = blk_q ? idx1_rd : idx0_rd;

  // score pipe: index read, add, two remainder stages, syndrome read, count
  logic [CW-1:0] k_q, upc_q;
  logic [4:0]    vld_q;
  logic [15:0]   sum_q, rem1_q;
  logic [7:0]    lo_q;
  logic [14:0]   addr_q;
  logic [15:0]   rem1_d, rem2_d;

  assign k_addr    = k_q[IAW-1:0];
  assign syn_raddr = SAW'(addr_q);

  // restoring remainder, high byte of the sum
  always_comb begin
    rem1_d = '0;
    for (int i = 7; i >= 0; i--) begin
      rem1_d = {rem1_d[14:0], sum_q[8+i]};
      if (rem1_d >= r16) rem1_d = rem1_d - r16;
    end
  end

  // restoring remainder, low byte
  always_comb begin
    rem2_d = rem1_q;
    for (int i = 7; i >= 0; i--) begin
      rem2_d = {rem2_d[14:0], lo_q[i]};
      if (rem2_d >= r16) rem2_d = rem2_d - r16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      k_q   <= '0;
      upc_q <= '0;
    end else begin
      if (cmd_i.issue) k_q <= k_q + CW'(1);
      if (vld_q[4] && syn_rd) upc_q <= upc_q + CW'(1);
    end
    sum_q  <= {1'b0, p_q} + {2'b00, idx_rd};
    rem1_q <= rem1_d;
    lo_q   <= sum_q[7:0];
    addr_q <= rem2_d[14:0];
  end

  // histograms with per-bin valid bits
  logic [HAW-1:0] h_raddr;
  logic [31:0]    e_rd, c_rd, e_val, c_val, e_inc, c_inc;
  logic [HD-1:0]  evld_q, cvld_q;
  logic           evrd_q, cvrd_q, e_we, c_we;

  assign h_raddr = cmd_i.hist_upc ? upc_q : bin_q;
  assign e_we    = cmd_i.hist_wr && bit_q;
  assign c_we    = cmd_i.hist_wr && !bit_q;
  assign e_val   = evrd_q ? e_rd : '0;
  assign c_val   = cvrd_q ? c_rd : '0;
  assign e_inc   = (e_val == BIN_MAX) ? e_val : e_val + 32'd1;
  assign c_inc   = (c_val == BIN_MAX) ? c_val : c_val + 32'd1;

  qmuh_ram #(.WIDTH(32), .DEPTH(HD)) u_err_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(upc_q),
    .wdata_i(e_inc),
    .raddr_i(h_raddr),
    .rdata_o(e_rd)
  );

  qmuh_ram #(.WIDTH(32), .DEPTH(HD)) u_cor_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(upc_q),
    .wdata_i(c_inc),
    .raddr_i(h_raddr),
    .rdata_o(c_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evld_q <= '0;
      cvld_q <= '0;
    end else if (cmd_i.clr) begin
      evld_q <= '0;
      cvld_q <= '0;
    end else begin
      if (e_we) evld_q[upc_q] <= 1'b1;
      if (c_we) cvld_q[upc_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    evrd_q <= evld_q[h_raddr];
    cvrd_q <= cvld_q[h_raddr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.hist_upc) begin
        upc_count_o         <= 8'(upc_q);
        error_bin_count_o   <= '0;
        correct_bin_count_o <= '0;
        result_kind_o       <= KIND_SCORE;
      end else begin
        upc_count_o         <= '0;
        error_bin_count_o   <= bin_ok_q ? e_val : '0;
        correct_bin_count_o <= bin_ok_q ? c_val : '0;
        result_kind_o       <= KIND_HIST;
      end
    end
  end

  // status
  assign st_o.score_ok   = score_ok_q;
  assign st_o.list_empty = (n_q == '0);
  assign st_o.issue_last = ((CW+1)'(k_q) + (CW+1)'(1)) == {1'b0, n_q};
  assign st_o.pipe_busy  = |vld_q;
  assign st_o.out_free   = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

/* dv/tb_qc_mdpc_upc_counter_histogram_unit.sv */
`default_nettype none
// Score tracker: holds the expected syndrome, index lists and histograms of the unit.
class upc_tracker;
  bit          syn_mem[16384];
  logic [13:0] list0[128];
  logic [13:0] list1[128];
  int unsigned cnt0, cnt1;
  bit [31:0]   err_hist[129];
  bit [31:0]   ok_hist[129];
  int unsigned ring;
  typedef struct packed {
    logic [7:0]  upc;
    logic [31:0] err;
    logic [31:0] ok;
    logic        kind;
  } res_t;
  res_t        pending[$];
  int          errors;

  function new();
    ring = 12323;
    cnt0 = 0;
    cnt1 = 0;
    errors = 0;
    foreach (err_hist[i]) begin
      err_hist[i] = 0;
      ok_hist[i] = 0;
    end
  endfunction

  function int unsigned eff_ring();
    if (ring < 2) return 2;
    if (ring > 16384) return 16384;
    return ring;
  endfunction

  // note one accepted input transaction
  function void note_input(logic [2:0] op, logic [14:0] pos, logic [13:0] idx, logic b);
    int unsigned r, p, n, upc, a;
    res_t e;
    r = eff_ring();
    upc = 0;
    case (op)
      qmuh_pkg::OP_LOAD_SYN: if (pos < 16384) syn_mem[pos] = b;
      qmuh_pkg::OP_APPEND0: if (cnt0 < 128) begin
        list0[cnt0] = idx;
        cnt0++;
      end
      qmuh_pkg::OP_APPEND1: if (cnt1 < 128) begin
        list1[cnt1] = idx;
        cnt1++;
      end
      qmuh_pkg::OP_SCORE: begin
        if (pos >= 2 * r) return;
        if (pos < r) begin
          p = pos;
          n = cnt0;
        end else begin
          p = pos - r;
          n = cnt1;
        end
        for (int k = 0; k < n; k++) begin
          a = (p + ((pos < r) ? list0[k] : list1[k])) % r;
          if (syn_mem[a]) upc++;
        end
        if (b) begin
          if (err_hist[upc] != qmuh_pkg::BIN_MAX) err_hist[upc]++;
        end else begin
          if (ok_hist[upc] != qmuh_pkg::BIN_MAX) ok_hist[upc]++;
        end
        e.upc = upc[7:0];
        e.err = 0;
        e.ok = 0;
        e.kind = qmuh_pkg::KIND_SCORE;
        pending.push_back(e);
      end
      qmuh_pkg::OP_READ_HIST: begin
        e.upc = 0;
        e.err = (pos <= 128) ? err_hist[pos] : 0;
        e.ok = (pos <= 128) ? ok_hist[pos] : 0;
        e.kind = qmuh_pkg::KIND_HIST;
        pending.push_back(e);
      end
      qmuh_pkg::OP_CLEAR: foreach (err_hist[i]) begin
        err_hist[i] = 0;
        ok_hist[i] = 0;
      end
      default: ;
    endcase
  endfunction

  // compare one result transaction against the oldest expectation
  function void check_result(res_t got);
    res_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: %h", got);
      return;
    end
    e = pending.pop_front();
    if (got !== e) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp upc=%0d err=%0d ok=%0d kind=%0b, %s",
                 e.upc, e.err, e.ok, e.kind,
                 $sformatf("got upc=%0d err=%0d ok=%0d kind=%0b",
                           got.upc, got.err, got.ok, got.kind));
    end
  endfunction
endclass

module tb_qc_mdpc_upc_counter_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qmuh_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  qmuh_in_if  in_if ();
  qmuh_out_if out_if ();

  qc_mdpc_upc_counter_histogram_unit u_top (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  upc_tracker tracker = new();
  int  idle_cycles = 0;
  bit  no_idle = 0;
  bit  hold_off = 0;
  bit  failed = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = '0;
    in_if.position = '0;
    in_if.index_value = '0;
    in_if.bit_value = 1'b0;
    out_if.ready = 1'b0;
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.check_result({out_if.upc_count, out_if.error_bin_count,
                            out_if.correct_bin_count, out_if.result_kind});
    out_if.ready <= rst_ni && !hold_off && (no_idle || $urandom_range(99) >= 33);
  end

  task automatic reg_write(logic [14:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {17'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tracker.ring = val;
  endtask

  // send one input transaction, with a random gap before it unless no_idle is set; called
  // at a clock edge, valid stays high after acceptance so the next transaction can follow directly
  task automatic send(logic [2:0] op, logic [14:0] pos, logic [13:0] idx, logic b);
    if (!no_idle)
      while ($urandom_range(99) < 33) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.position <= pos;
    in_if.index_value <= idx;
    in_if.bit_value <= b;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_input(op, pos, idx, b);
  endtask

  // end of a run of transactions, called at the last acceptance edge
  task automatic stop_input();
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // load syndrome bits 0..r-1 and append w index values to both lists; index values stay small so that
  // wide rings only touch loaded syndrome bits
  task automatic load_code(int unsigned r, int unsigned w);
    for (int a = 0; a < r; a++) send(OP_LOAD_SYN, 15'(a), 14'd0, 1'($urandom_range(1)));
    for (int k = 0; k < w; k++) begin
      send(OP_APPEND0, 15'd0, 14'($urandom_range(63)), 1'b0);
      send(OP_APPEND1, 15'd0, 14'($urandom_range(63)), 1'b0);
    end
  endtask

  // most scores pick an in-block offset below span in either block; some use positions from 2r up
  task automatic random_phase(int unsigned r, int unsigned span, int cnt);
    int unsigned s, p;
    for (int i = 0; i < cnt; i++) begin
      s = $urandom_range(99);
      p = $urandom_range(span - 1);
      if ($urandom_range(1) == 1) p = p + r;
      if (s < 65) send(OP_SCORE, 15'(p), 14'($urandom), 1'($urandom));
      else if (s < 75)
        send(OP_READ_HIST, 15'($urandom_range(135)), 14'($urandom), 1'($urandom));
      else if (s < 82)
        send(OP_LOAD_SYN, 15'($urandom_range(r - 1)), 14'($urandom), 1'($urandom));
      else if (s < 85) send(OP_APPEND0, 15'($urandom), 14'($urandom), 1'($urandom));
      else if (s < 88) send(OP_APPEND1, 15'($urandom), 14'($urandom), 1'($urandom));
      else if (s < 90) send(OP_CLEAR, 15'($urandom), 14'($urandom), 1'($urandom));
      else if (s < 93)
        send(3'(3'd6 + $urandom_range(1)), 15'($urandom), 14'($urandom), 1'($urandom));
      else if (2 * r <= 32767)
        send(OP_SCORE, 15'($urandom_range(32767, 2 * r)), 14'($urandom), 1'($urandom));
      else send(OP_SCORE, 15'(p), 14'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small ring, edge cases
    reg_write(15'd0);
    send(OP_LOAD_SYN, 0, 0, 1);
    send(OP_LOAD_SYN, 1, 0, 0);
    send(OP_LOAD_SYN, 15'h7FFF, 14'h3FFF, 1);
    send(OP_SCORE, 0, 0, 1);
    send(OP_SCORE, 3, 0, 0);
    send(OP_APPEND0, 0, 14'h3FFF, 0);
    send(OP_APPEND0, 0, 14'd0, 0);
    send(OP_APPEND0, 0, 14'd0, 0);
    send(OP_APPEND1, 0, 14'd1, 0);
    send(OP_SCORE, 0, 0, 1);
    send(OP_SCORE, 1, 0, 0);
    send(OP_SCORE, 2, 0, 1);
    send(OP_SCORE, 4, 0, 1);
    send(OP_SCORE, 15'h7FFF, 0, 1);
    send(OP_READ_HIST, 0, 0, 0);
    send(OP_READ_HIST, 2, 0, 0);
    send(OP_READ_HIST, 128, 0, 0);
    send(OP_READ_HIST, 15'h7FFF, 0, 0);
    send(3'd6, 0, 0, 0);
    send(3'd7, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_READ_HIST, 2, 0, 0);
    stop_input();
    drain();

    // fill the lists past full with a mid ring
    reg_write(15'd97);
    load_code(97, 130);
    random_phase(97, 97, 100);

    // back pressure: results held off while inputs keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        random_phase(97, 97, 40);
        stop_input();
      end
    join
    drain();

    // largest ring, no idling on either side; only low offsets are scored
    reg_write(15'h7FFF);
    no_idle = 1;
    load_code(128, 0);
    send(OP_LOAD_SYN, 15'd16383, 14'd0, 1'b1);
    random_phase(16384, 64, 80);
    stop_input();
    no_idle = 0;
    drain();

    reg_write(15'd5);
    load_code(5, 0);
    random_phase(5, 5, 100);
    stop_input();
    drain();

    failed = tracker.errors != 0 || tracker.pending.size() != 0;
    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
